[design/rlrc_pkg.sv]
// ----------------------------------------------------------------------------
// rlrc_pkg
// Shared types, codes and default settings for the rate limited recovery
// controller.
// ----------------------------------------------------------------------------
package rlrc_pkg;

  // default settings used when a register holds zero
  localparam logic [15:0] DefaultCooldown = 16'd60;
  localparam logic [15:0] DefaultWindow   = 16'd300;
  localparam logic [7:0]  DefaultLimit    = 8'd3;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RECOVERY_ON  = 2'd0,
    CFG_WINDOW_SEC   = 2'd1,
    CFG_RESTART_LIM  = 2'd2,
    CFG_COOLDOWN_SEC = 2'd3
  } cfg_idx_e;

  // command codes
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_START   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_FIXPORT = 2'd3
  } cmd_e;

  // status codes
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_COOLDOWN = 3'd1,
    ST_RESUMED  = 3'd2,
    ST_START    = 3'd3,
    ST_RESTART  = 3'd4,
    ST_FIXPORT  = 3'd5
  } status_e;

  // input item: one health poll
  typedef struct packed {
    logic [31:0] now_seconds;
    logic        service_up;
    logic        port_listening;
    logic        port_setting_ok;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  status;
    logic        cooling_down;
    logic [15:0] cooldown_left;
    logic [7:0]  window_restarts;
    logic [31:0] total_recoveries;
  } out_item_t;

  // effective settings, defaults already applied
  typedef struct packed {
    logic        recovery_on;
    logic [15:0] window_len;
    logic [7:0]  limit;
    logic [15:0] cooldown_len;
  } cfg_t;

endpackage

[design/rlrc_cfg.sv]
// ----------------------------------------------------------------------------
// rlrc_cfg
// Configuration registers with fall-back to default settings on zero.
// ----------------------------------------------------------------------------
module rlrc_cfg #(
  parameter logic [15:0] DEFAULT_COOLDOWN = rlrc_pkg::DefaultCooldown,
  parameter logic [15:0] DEFAULT_WINDOW   = rlrc_pkg::DefaultWindow,
  parameter logic [7:0]  DEFAULT_LIMIT    = rlrc_pkg::DefaultLimit
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rlrc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [rlrc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output rlrc_pkg::cfg_t                       cfg_o
);
  import rlrc_pkg::*;

  logic        recovery_on_q;
  logic [15:0] window_q;
  logic [7:0]  limit_q;
  logic [15:0] cooldown_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_on_q <= 1'b1;
      window_q      <= '0;
      limit_q       <= '0;
      cooldown_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RECOVERY_ON:  recovery_on_q <= cfg_data_i[0];
        CFG_WINDOW_SEC:   window_q      <= cfg_data_i;
        CFG_RESTART_LIM:  limit_q       <= cfg_data_i[7:0];
        CFG_COOLDOWN_SEC: cooldown_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero selects the default
  always_comb begin
    cfg_o.recovery_on  = recovery_on_q;
    cfg_o.window_len   = (window_q == '0) ? DEFAULT_WINDOW : window_q;
    cfg_o.limit        = (limit_q == '0) ? DEFAULT_LIMIT : limit_q;
    cfg_o.cooldown_len = (cooldown_q == '0) ? DEFAULT_COOLDOWN : cooldown_q;
  end

endmodule

[design/rlrc_core.sv]
// ----------------------------------------------------------------------------
// rlrc_core
// Recovery state and the decision for one poll; state advances on step_i.
// ----------------------------------------------------------------------------
module rlrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rlrc_pkg::cfg_t      cfg_i,
  input  rlrc_pkg::in_item_t  item_i,
  output rlrc_pkg::out_item_t result_o
);
  import rlrc_pkg::*;

  logic        in_cd_q, in_cd_d;
  logic [31:0] cd_end_q, cd_end_d;
  logic [31:0] win_begin_q, win_begin_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] total_q, total_d;
  status_e     status_q, status_d;

  logic [31:0] now;
  logic        pending, resume;
  logic [7:0]  count1, count2, count3;
  logic [31:0] win_begin1, since;
  status_e     status1, fail_status;
  cmd_e        fail_cmd, cmd;
  logic        win_over, healthy;
  logic [32:0] end_sum;
  logic [31:0] end_new, left_full;

  assign now = item_i.now_seconds;

  // cooldown check, resume when expired
  assign pending    = in_cd_q && (now < cd_end_q);
  assign resume     = in_cd_q && !pending;
  assign count1     = resume ? 8'd0 : count_q;
  assign win_begin1 = resume ? now : win_begin_q;
  assign status1    = in_cd_q ? (pending ? ST_COOLDOWN : ST_RESUMED) : status_q;

  // window expiry
  assign since    = now - win_begin1;
  assign win_over = (now >= win_begin1) && (since >= {16'd0, cfg_i.window_len});
  assign count2   = win_over ? 8'd0 : count1;
  assign count3   = count2 + 8'd1;

  // saturating cooldown end for a cooldown starting now
  assign end_sum = {1'b0, now} + {17'd0, cfg_i.cooldown_len};
  assign end_new = end_sum[32] ? '1 : end_sum[31:0];

  assign healthy = item_i.service_up && item_i.port_listening && item_i.port_setting_ok;

  // first failing check picks the command
  always_comb begin
    if (!item_i.service_up) begin
      fail_cmd    = CMD_START;
      fail_status = ST_START;
    end else if (!item_i.port_listening) begin
      fail_cmd    = CMD_RESTART;
      fail_status = ST_RESTART;
    end else begin
      fail_cmd    = CMD_FIXPORT;
      fail_status = ST_FIXPORT;
    end
  end

  // next state
  always_comb begin
    in_cd_d     = pending;
    cd_end_d    = pending ? cd_end_q : 32'd0;
    win_begin_d = win_begin1;
    count_d     = count1;
    total_d     = total_q;
    status_d    = status1;
    cmd         = CMD_NONE;
    if (!cfg_i.recovery_on) begin
      status_d = pending ? ST_COOLDOWN : ST_NONE;
    end else if (pending) begin
      status_d = ST_COOLDOWN;
    end else if (healthy) begin
      status_d = (status1 == ST_COOLDOWN) ? ST_COOLDOWN : ST_NONE;
    end else begin
      win_begin_d = win_over ? now : win_begin1;
      count_d     = count2;
      if (count2 < cfg_i.limit) begin
        cmd      = fail_cmd;
        status_d = fail_status;
        count_d  = count3;
        total_d  = total_q + 32'd1;
        if (count3 >= cfg_i.limit) begin
          in_cd_d  = 1'b1;
          cd_end_d = end_new;
          status_d = ST_COOLDOWN;
        end
      end else begin
        in_cd_d  = 1'b1;
        cd_end_d = end_new;
        status_d = ST_COOLDOWN;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cd_q     <= 1'b0;
      cd_end_q    <= '0;
      win_begin_q <= '0;
      count_q     <= '0;
      total_q     <= '0;
      status_q    <= ST_NONE;
    end else if (step_i) begin
      in_cd_q     <= in_cd_d;
      cd_end_q    <= cd_end_d;
      win_begin_q <= win_begin_d;
      count_q     <= count_d;
      total_q     <= total_d;
      status_q    <= status_d;
    end
  end

  // result fields
  assign left_full = cd_end_d - now;
  always_comb begin
    result_o.command          = cmd;
    result_o.status           = status_d;
    result_o.cooling_down     = in_cd_d;
    result_o.window_restarts  = count_d;
    result_o.total_recoveries = total_d;
    result_o.cooldown_left    = '0;
    if ((cd_end_d != '0) && (now < cd_end_d)) begin
      result_o.cooldown_left = (left_full[31:16] != '0) ? 16'hFFFF : left_full[15:0];
    end
  end

endmodule

[design/rate_limited_recovery_controller.sv]
// ----------------------------------------------------------------------------
// rate_limited_recovery_controller
// Health poll in, one recovery decision out, restarts limited per window
// with a cooldown once the limit is reached.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  poll    | in_valid_i, in_ready_o, in_item_i        | in
//  result  | out_valid_o, out_ready_i, out_item_o     | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//
//  an item is held in the input register, its decision is made in one pass of
//  logic and lands in the result register; one item per cycle is sustained
//  while out_ready_i stays high.
//  reset clears all recovery state; recovery_on comes up set.
//  when the result register is held by out_ready_i low, the input register
//  holds its item and in_ready_o drops once both are full.
// ----------------------------------------------------------------------------
module rate_limited_recovery_controller #(
  parameter logic [15:0] DEFAULT_COOLDOWN = rlrc_pkg::DefaultCooldown,
  parameter logic [15:0] DEFAULT_WINDOW   = rlrc_pkg::DefaultWindow,
  parameter logic [7:0]  DEFAULT_LIMIT    = rlrc_pkg::DefaultLimit
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rlrc_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rlrc_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [rlrc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [rlrc_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import rlrc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_vld_q;
  out_item_t result;
  out_item_t out_item_q;
  logic      out_vld_q;
  logic      step;

  rlrc_cfg #(
    .DEFAULT_COOLDOWN(DEFAULT_COOLDOWN),
    .DEFAULT_WINDOW  (DEFAULT_WINDOW),
    .DEFAULT_LIMIT   (DEFAULT_LIMIT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  // item moves on when the result register is free or being drained
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  rlrc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .item_i  (in_item_q),
    .result_o(result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

[test/rate_limited_recovery_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_limited_recovery_controller_tb
// Self-checking bench for the recovery controller: a queue of health polls is
// driven through the poll channel, each accepted poll is run through a local
// model of the restart window and cooldown logic, and every result item is
// compared field by field against the oldest prediction. Both channels idle
// and stall at random; registers change only between drained phases.
// ----------------------------------------------------------------------------
module rate_limited_recovery_controller_tb;
  import rlrc_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  in_item_t                in_item_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  out_item_t               out_item_o;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  // model copy of the registers
  logic        rec_on  = 1'b1;
  logic [15:0] win_cfg = '0;
  logic [7:0]  lim_cfg = '0;
  logic [15:0] cd_cfg  = '0;

  // model copy of the recovery state
  logic        cooling    = 1'b0;
  logic [31:0] cd_end     = '0;
  logic [31:0] win_begin  = '0;
  logic [7:0]  restarts   = '0;
  logic [31:0] recoveries = '0;
  status_e     cur_status = ST_NONE;

  in_item_t    pending_polls[$];
  out_item_t   expected_results[$];
  int          mismatches        = 0;
  int          send_gap          = 0;
  int          stall_left        = 0;
  int          ready_hold_cycles = 0;
  bit          poll_taken        = 1'b0;
  bit          idle_mode         = 1'b1;
  logic [31:0] poll_clock        = '0;

  rate_limited_recovery_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s mismatch, got %0d want %0d", $time, field, got, want);
    end
  endtask

  // one poll through the recovery decision, updating the model state
  task automatic predict_poll(input in_item_t poll, output out_item_t res);
    cmd_e        cmd;
    status_e     pick;
    logic [31:0] now_s;
    logic [31:0] gap;
    logic [15:0] win;
    logic [15:0] cd;
    logic [7:0]  lim;
    logic [32:0] cd_sum;
    now_s = poll.now_seconds;
    win   = (win_cfg != 0) ? win_cfg : DefaultWindow;
    lim   = (lim_cfg != 0) ? lim_cfg : DefaultLimit;
    cd    = (cd_cfg != 0) ? cd_cfg : DefaultCooldown;
    cmd   = CMD_NONE;
    pick  = ST_NONE;

    // an expired cooldown resumes before anything else
    if (cooling) begin
      if (now_s < cd_end) begin
        cur_status = ST_COOLDOWN;
      end else begin
        cooling    = 1'b0;
        cd_end     = '0;
        restarts   = '0;
        win_begin  = now_s;
        cur_status = ST_RESUMED;
      end
    end

    if (!rec_on) begin
      if (!cooling) cur_status = ST_NONE;
    end else if (cooling) begin
      cur_status = ST_COOLDOWN;
    end else if (poll.service_up && poll.port_listening && poll.port_setting_ok) begin
      if (cur_status != ST_COOLDOWN) cur_status = ST_NONE;
    end else begin
      // first failing check picks the command
      if (!poll.service_up) begin
        cmd  = CMD_START;
        pick = ST_START;
      end else if (!poll.port_listening) begin
        cmd  = CMD_RESTART;
        pick = ST_RESTART;
      end else begin
        cmd  = CMD_FIXPORT;
        pick = ST_FIXPORT;
      end
      // window rolls over only when time has moved forward past it
      if (now_s >= win_begin && (now_s - win_begin) >= {16'd0, win}) begin
        win_begin = now_s;
        restarts  = '0;
      end
      if (restarts < lim) begin
        cur_status = pick;
        restarts   = restarts + 8'd1;
        recoveries = recoveries + 32'd1;
      end else begin
        cmd = CMD_NONE;
      end
      // at or over the limit: cooldown, end saturating at the top second
      if (restarts >= lim) begin
        cooling    = 1'b1;
        cd_sum     = {1'b0, now_s} + {17'd0, cd};
        cd_end     = cd_sum[32] ? 32'hFFFF_FFFF : cd_sum[31:0];
        cur_status = ST_COOLDOWN;
      end
    end

    gap = '0;
    if (cd_end != 0 && now_s < cd_end) gap = cd_end - now_s;
    res.command          = cmd;
    res.status           = cur_status;
    res.cooling_down     = cooling;
    res.cooldown_left    = (gap > 32'hFFFF) ? 16'hFFFF : gap[15:0];
    res.window_restarts  = restarts;
    res.total_recoveries = recoveries;
  endtask

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // poll channel: note acceptance and predict
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_poll(in_item_i, exp_res);
      expected_results.push_back(exp_res);
      poll_taken = 1'b1;
    end
  end

  // poll channel: present the next item once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || poll_taken)) begin
      poll_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_polls.size() != 0) begin
        in_item_i  <= pending_polls.pop_front();
        in_valid_i <= 1'b1;
        if (idle_mode && $urandom_range(0, 3) == 0) send_gap = pause_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result channel: compare against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_item_o.total_recoveries, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.command !== want.command)
          report_mismatch("command", 32'(out_item_o.command), 32'(want.command));
        if (out_item_o.status !== want.status)
          report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
        if (out_item_o.cooling_down !== want.cooling_down)
          report_mismatch("cooling_down", 32'(out_item_o.cooling_down),
                          32'(want.cooling_down));
        if (out_item_o.cooldown_left !== want.cooldown_left)
          report_mismatch("cooldown_left", 32'(out_item_o.cooldown_left),
                          32'(want.cooldown_left));
        if (out_item_o.window_restarts !== want.window_restarts)
          report_mismatch("window_restarts", 32'(out_item_o.window_restarts),
                          32'(want.window_restarts));
        if (out_item_o.total_recoveries !== want.total_recoveries)
          report_mismatch("total_recoveries", out_item_o.total_recoveries,
                          want.total_recoveries);
      end
    end
  end

  // result channel: long hold-off first, then random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        stall_left = pause_len();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic add_poll(input logic [31:0] sec, input logic [2:0] flags);
    in_item_t p;
    p.now_seconds     = sec;
    p.service_up      = flags[2];
    p.port_listening  = flags[1];
    p.port_setting_ok = flags[0];
    pending_polls.push_back(p);
  endtask

  // time mostly creeps forward, with jumps, rare steps back and rare leaps
  function automatic logic [31:0] next_second(input logic [31:0] cur);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return cur + $urandom_range(0, 3);
    if (r < 78) return cur + $urandom_range(4, 40);
    if (r < 92) return cur + $urandom_range(41, 700);
    if (r < 96) return cur + $urandom_range(0, 200000);
    if (r < 98) return cur - $urandom_range(1, 50);
    return $urandom;
  endfunction

  task automatic queue_random_polls(input int n);
    logic [2:0] flags;
    for (int i = 0; i < n; i++) begin
      poll_clock = next_second(poll_clock);
      flags = ($urandom_range(0, 9) < 4) ? 3'b111 : 3'($urandom_range(0, 6));
      add_poll(poll_clock, flags);
    end
  endtask

  // sender holds back until every predicted result has come out
  task automatic drain();
    while (pending_polls.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_RECOVERY_ON:  rec_on  = val[0];
      CFG_WINDOW_SEC:   win_cfg = val;
      CFG_RESTART_LIM:  lim_cfg = val[7:0];
      CFG_COOLDOWN_SEC: cd_cfg  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic on, input logic [15:0] win, input logic [7:0] lim,
                           input logic [15:0] cd, input logic [31:0] base,
                           input bit long_hold);
    drain();
    write_reg(CFG_RECOVERY_ON, {15'd0, on});
    write_reg(CFG_WINDOW_SEC, win);
    write_reg(CFG_RESTART_LIM, {8'd0, lim});
    write_reg(CFG_COOLDOWN_SEC, cd);
    poll_clock = base;
    queue_random_polls(52);
    if (long_hold) begin
      @(posedge clk_i);
      ready_hold_cycles = 400;
    end
  endtask

  initial begin
    int spins;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_RECOVERY_ON;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings: limit 3, window 300, cooldown 60
    add_poll(32'd0, 3'b111);
    add_poll(32'd0, 3'b011);          // service down
    add_poll(32'd1, 3'b101);          // port not listening
    add_poll(32'd2, 3'b110);          // port setting wrong, limit reached
    add_poll(32'd3, 3'b000);          // held in cooldown
    add_poll(32'd3, 3'b111);          // healthy keeps cooldown status
    add_poll(32'd62, 3'b111);         // resumed then healthy
    add_poll(32'd63, 3'b000);
    add_poll(32'd400, 3'b101);        // window elapsed
    add_poll(32'd399, 3'b011);        // time going backwards
    add_poll(32'd400, 3'b110);
    add_poll(32'hFFFF_FFC0, 3'b110);  // resume and act in the same poll
    add_poll(32'hFFFF_FFF0, 3'b101);
    add_poll(32'hFFFF_FFFF, 3'b011);  // cooldown end saturates
    add_poll(32'hFFFF_FFFF, 3'b000);
    add_poll(32'hFFFF_FFFF, 3'b000);
    add_poll(32'hFFFF_FFFF, 3'b000);
    drain();

    // recovery off with a cooldown still pending, then resumed while off
    write_reg(CFG_RECOVERY_ON, 16'd0);
    add_poll(32'd1000, 3'b000);
    add_poll(32'hFFFF_FFFF, 3'b000);
    add_poll(32'hFFFF_FFFF, 3'b111);

    // random phases across settings, extremes first
    run_phase(1'b1, 16'd0, 8'd0, 16'd0, 32'd0, 1'b0);
    run_phase(1'b1, 16'd5, 8'd2, 16'd10, $urandom, 1'b1);
    idle_mode = 1'b0;
    run_phase(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_F000, 1'b0);
    idle_mode = 1'b1;
    run_phase(1'b1, 16'd1, 8'd1, 16'd1, $urandom, 1'b0);
    run_phase(1'b0, 16'd7, 8'd1, 16'd3, 32'd100, 1'b0);
    run_phase(1'b1, 16'd20, 8'd4, 16'd30, $urandom, 1'b0);
    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = (ph != 2);
      run_phase($urandom_range(0, 5) != 0,
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 120)),
                8'($urandom_range(0, 6)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90)),
                (ph % 2 == 0) ? $urandom : 32'($urandom_range(0, 5000)),
                ph == 3);
    end

    // wait for the last results, bounded
    spins = 0;
    while ((pending_polls.size() != 0 || in_valid_i || expected_results.size() != 0)
           && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 32'(expected_results.size()), 32'd0);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
